### design/assert_macros.svh
// assertion helpers used by triangle_depth_sort_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// condition in one cycle forces a condition in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tds_pkg.sv
package tds_pkg;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CAMERA_Z = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_INSERT,
        ST_EMIT
    } tds_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic square;
        logic insert;
        logic pop;
        logic clear;
    } tds_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic complete;
        logic empty;
    } tds_stat_t;

endpackage

### design/triangle_depth_sort_unit.sv
// a corner that does not close a triangle is only captured; a closing corner is captured,
// squared and then sorted into the cell row
// after the last corner the results are emitted, one result per cycle while m_tready is high
// output back-pressure holds the head cell; no input is taken during emission
// rst_n clears state, camera registers and cell valid bits at once; no clearing pass
`include "assert_macros.svh"

module triangle_depth_sort_unit
    import tds_pkg::*;
#(
    parameter int MAX_TRIANGLES = 64,
    parameter int COORD_BITS    = 16,
    parameter int INDEX_BITS    = 24,
    localparam int IN_W  = ((INDEX_BITS + 3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * INDEX_BITS + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COORD_BITS-1:0]    cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // vertex_index, pos_x, pos_y, pos_z
    input  logic [IN_W-1:0]          s_tdata,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // first_vertex, second_vertex, third_vertex
    output logic [OUT_W-1:0]         m_tdata,
    output logic                     m_tlast,
    // dropped
    output logic                     m_tuser
);

    tds_cmd_t              cmd;
    tds_stat_t             stat;
    logic [INDEX_BITS-1:0] first_vertex;
    logic [INDEX_BITS-1:0] second_vertex;
    logic [INDEX_BITS-1:0] third_vertex;

    tds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    tds_datapath #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_BITS    (COORD_BITS),
        .INDEX_BITS    (INDEX_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .vertex_index   (s_tdata[INDEX_BITS-1:0]),
        .pos_x          (s_tdata[INDEX_BITS+COORD_BITS-1:INDEX_BITS]),
        .pos_y          (s_tdata[INDEX_BITS+2*COORD_BITS-1:INDEX_BITS+COORD_BITS]),
        .pos_z          (s_tdata[INDEX_BITS+3*COORD_BITS-1:INDEX_BITS+2*COORD_BITS]),
        .last_corner    (s_tlast),
        .first_vertex   (first_vertex),
        .second_vertex  (second_vertex),
        .third_vertex   (third_vertex),
        .final_triangle (m_tlast),
        .dropped        (m_tuser)
    );

    // pack result
    assign m_tdata = OUT_W'({third_vertex, second_vertex, first_vertex});

    // checks
    `ASSERT_NEVER(a_one_side_active, s_tready && m_tvalid, "input and output active together")
    `ASSERT_NEXT(a_final_ends_run, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after final")
    `ASSERT_NEXT(a_last_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last")

endmodule

### design/tds_ctrl.sv
module tds_ctrl
    import tds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    input  logic      m_tready,
    input  tds_stat_t stat,
    output tds_cmd_t  cmd,
    output logic      s_tready,
    output logic      m_tvalid
);

    tds_state_t state_reg;
    tds_state_t state_next;
    logic       last_reg;
    logic       last_next;
    logic       s_fire;

    assign s_fire = s_tvalid && s_tready;

    // state and pending end-of-set flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    last_next = s_tlast;
                    if (stat.complete)
                        state_next = ST_SQUARE;
                    else if (s_tlast)
                        state_next = ST_EMIT;
                end
            end
            ST_SQUARE:
                state_next = ST_INSERT;
            ST_INSERT:
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (stat.empty)
                begin
                    state_next = ST_IDLE;
                    last_next  = 1'b0;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid   = (state_reg == ST_EMIT) && !stat.empty;
        cmd.accept = s_tvalid && (state_reg == ST_IDLE);
        cmd.square = (state_reg == ST_SQUARE);
        cmd.insert = (state_reg == ST_INSERT);
        cmd.pop    = m_tvalid && m_tready;
        cmd.clear  = (state_reg == ST_EMIT) && stat.empty;
    end

endmodule

### design/tds_datapath.sv
module tds_datapath
    import tds_pkg::*;
#(
    parameter int MAX_TRIANGLES = 64,
    parameter int COORD_BITS    = 16,
    parameter int INDEX_BITS    = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tds_cmd_t                       cmd,
    output tds_stat_t                      stat,
    input  logic                           cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]       cfg_addr,
    input  logic [COORD_BITS-1:0]          cfg_wdata,
    input  logic [INDEX_BITS-1:0]          vertex_index,
    input  logic signed [COORD_BITS-1:0]   pos_x,
    input  logic signed [COORD_BITS-1:0]   pos_y,
    input  logic signed [COORD_BITS-1:0]   pos_z,
    input  logic                           last_corner,
    output logic [INDEX_BITS-1:0]          first_vertex,
    output logic [INDEX_BITS-1:0]          second_vertex,
    output logic [INDEX_BITS-1:0]          third_vertex,
    output logic                           final_triangle,
    output logic                           dropped
);

    localparam int SUM_W  = COORD_BITS + 2;
    localparam int DIFF_W = COORD_BITS + 3;
    localparam int KEY_W  = 2 * DIFF_W;
    localparam int TRI_W  = 3 * INDEX_BITS;

    logic signed [COORD_BITS-1:0] cam_reg [3];
    logic [1:0]                   count_reg;
    logic signed [SUM_W-1:0]      sum_reg  [3];
    logic signed [SUM_W-1:0]      sum_next [3];
    logic [INDEX_BITS-1:0]        pend_reg [2];
    logic signed [SUM_W-1:0]      tsum_reg [3];
    logic [TRI_W-1:0]             tri_new_reg;
    logic [KEY_W-1:0]             sq_reg   [3];
    logic [KEY_W-1:0]             key_new;
    logic                         overflow_reg;

    logic [KEY_W-1:0]             key_reg   [MAX_TRIANGLES];
    logic [TRI_W-1:0]             tri_reg   [MAX_TRIANGLES];
    logic [MAX_TRIANGLES-1:0]     valid_reg;
    logic [KEY_W-1:0]             key_next  [MAX_TRIANGLES];
    logic [TRI_W-1:0]             tri_next  [MAX_TRIANGLES];
    logic [MAX_TRIANGLES-1:0]     valid_next;
    logic [MAX_TRIANGLES-1:0]     cell_yields;
    logic [MAX_TRIANGLES-1:0]     prev;
    logic                         full;

    assign stat.complete = (count_reg == 2'd2);
    assign stat.empty    = !valid_reg[0];
    assign full          = valid_reg[MAX_TRIANGLES-1];

    // camera registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_addr)
                CFG_CAMERA_X: cam_reg[0] <= cfg_wdata;
                CFG_CAMERA_Y: cam_reg[1] <= cfg_wdata;
                CFG_CAMERA_Z: cam_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // running corner sums
    always_comb
    begin
        sum_next[0] = sum_reg[0] + SUM_W'(pos_x);
        sum_next[1] = sum_reg[1] + SUM_W'(pos_y);
        sum_next[2] = sum_reg[2] + SUM_W'(pos_z);
    end

    // corner gathering
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end
        else if (cmd.accept)
        begin
            if (stat.complete || last_corner)
            begin
                count_reg <= '0;
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
                sum_reg[2] <= '0;
            end
            else
            begin
                count_reg <= count_reg + 2'd1;
                sum_reg[0] <= sum_next[0];
                sum_reg[1] <= sum_next[1];
                sum_reg[2] <= sum_next[2];
            end
        end
    end

    // pending corners and finished triangle hold
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (count_reg == 2'd0)
                pend_reg[0] <= vertex_index;
            if (count_reg == 2'd1)
                pend_reg[1] <= vertex_index;
            if (stat.complete)
            begin
                tsum_reg[0] <= sum_next[0];
                tsum_reg[1] <= sum_next[1];
                tsum_reg[2] <= sum_next[2];
                tri_new_reg <= {vertex_index, pend_reg[1], pend_reg[0]};
            end
        end
    end

    // squared distance per axis
    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            for (int a = 0; a < 3; a++)
            begin
                logic signed [DIFF_W-1:0] cam_w;
                logic signed [DIFF_W-1:0] d;
                cam_w = DIFF_W'(cam_reg[a]);
                d = DIFF_W'(tsum_reg[a]) - ((cam_w <<< 1) + cam_w);
                sq_reg[a] <= KEY_W'($signed(d) * $signed(d));
            end
        end
    end

    assign key_new = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // insertion and pop across the sorted cells
    always_comb
    begin
        for (int i = 0; i < MAX_TRIANGLES; i++)
            cell_yields[i] = !valid_reg[i] || (key_reg[i] < key_new);
        prev[0] = 1'b0;
        for (int i = 1; i < MAX_TRIANGLES; i++)
            prev[i] = cell_yields[i-1];

        for (int i = 0; i < MAX_TRIANGLES; i++)
        begin
            key_next[i]   = key_reg[i];
            tri_next[i]   = tri_reg[i];
            valid_next[i] = valid_reg[i];
        end

        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (cmd.insert && !full)
        begin
            for (int i = 0; i < MAX_TRIANGLES; i++)
            begin
                if (cell_yields[i] && !prev[i])
                begin
                    key_next[i]   = key_new;
                    tri_next[i]   = tri_new_reg;
                    valid_next[i] = 1'b1;
                end
            end
            for (int i = 1; i < MAX_TRIANGLES; i++)
            begin
                if (prev[i])
                begin
                    key_next[i]   = key_reg[i-1];
                    tri_next[i]   = tri_reg[i-1];
                    valid_next[i] = valid_reg[i-1];
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < MAX_TRIANGLES - 1; i++)
            begin
                key_next[i]   = key_reg[i+1];
                tri_next[i]   = tri_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            valid_next[MAX_TRIANGLES-1] = 1'b0;
        end
    end

    // cell valid bits and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.clear)
                overflow_reg <= 1'b0;
            else if (cmd.insert && full)
                overflow_reg <= 1'b1;
        end
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TRIANGLES; i++)
        begin
            key_reg[i] <= key_next[i];
            tri_reg[i] <= tri_next[i];
        end
    end

    // head cell drives the result
    assign first_vertex   = tri_reg[0][INDEX_BITS-1:0];
    assign second_vertex  = tri_reg[0][2*INDEX_BITS-1:INDEX_BITS];
    assign third_vertex   = tri_reg[0][TRI_W-1:2*INDEX_BITS];
    assign final_triangle = !valid_reg[1];
    assign dropped        = overflow_reg;

endmodule
